@@ rtl/slpd_pkg.sv @@
// ----------------------------------------------------------------------------
// slpd_pkg
// Shared types and constants of the start/length packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package slpd_pkg;

	// Bytes in one payload buffer; two buffers make up the store
	localparam int BUF_BYTES = 128;
	localparam int STORE_DEPTH = 2 * BUF_BYTES;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	// Field widths
	localparam int REQ_W = 2;
	localparam int BYTE_W = 8;
	localparam int OFF_W = 7;
	localparam int LEN_W = 8;

	// Frame start marker
	localparam logic [BYTE_W-1:0] START_BYTE = 8'h02;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_BYTE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

	// Store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

	// Store read port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	// Status of one transaction, known at acceptance
	typedef struct packed {
		logic             hit;
		logic             ready;
		logic [LEN_W-1:0] length;
		logic             dropped;
		logic             overrun;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/start_length_packet_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// start_length_packet_deframer_unit
// Deframes start/length framed bytes into two ping-pong payload buffers.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle, back to back, while out_stall is
// low. After its transaction is accepted, each result passes through stage
// 1 and then the output register, which holds it until it is taken. The stage
// in between covers the registered read port of the payload store. While the
// output is held off, one more transaction enters stage 1 before in_stall
// rises. Parse state, buffer lengths and selects update in the accept cycle,
// so a read or release directly after a frame-completing byte sees the
// published buffer. The payload store needs no clearing after reset: reads
// are limited to the published length, which only covers written bytes.
`default_nettype none

module start_length_packet_deframer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [slpd_pkg::REQ_W-1:0]  req_type,
	input  wire logic [slpd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [slpd_pkg::OFF_W-1:0]  read_offset,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [slpd_pkg::BYTE_W-1:0]      read_data,
	output logic                             packet_ready,
	output logic [slpd_pkg::LEN_W-1:0]       ready_length,
	output logic                             packet_dropped,
	output logic                             overrun
);
	import slpd_pkg::*;

	mem_wr_t           wr;
	mem_rd_t           rd;
	status_t           status;
	status_t           status_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] rdata;
	logic              advance;
	logic              accept;

	// Advance when the output register is empty or being taken
	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	slpd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.req_type    (req_type),
		.rx_byte     (rx_byte),
		.read_offset (read_offset),
		.wr          (wr),
		.rd          (rd),
		.status      (status)
	);

	slpd_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	// Stage 1: wait for the store read; fill on accept, empty when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			read_data <= status_s1.hit ? rdata : '0;
			packet_ready <= status_s1.ready;
			ready_length <= status_s1.length;
			packet_dropped <= status_s1.dropped;
			overrun <= status_s1.overrun;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_data_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data != '0) |-> packet_ready)
		else $error("read data returned without a ready packet");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(packet_dropped && overrun))
		else $error("drop and overrun flagged together");

	a_len_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_ready |-> ready_length == '0)
		else $error("length shown with no packet ready");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage 1");

endmodule

`default_nettype wire

@@ rtl/slpd_store.sv @@
// ----------------------------------------------------------------------------
// slpd_store
// Payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slpd_store (
	input  wire logic                    clk,
	input  wire slpd_pkg::mem_wr_t       wr,
	input  wire slpd_pkg::mem_rd_t       rd,
	output logic [slpd_pkg::BYTE_W-1:0]  rdata
);
	import slpd_pkg::*;

	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// Write payload bytes
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read; hold data otherwise
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/slpd_parse.sv @@
// ----------------------------------------------------------------------------
// slpd_parse
// Frame parser and buffer control: updates the parse state, the buffer
// lengths and the ping-pong selects for each accepted transaction, and
// drives the store ports.
// ----------------------------------------------------------------------------
`default_nettype none

module slpd_parse (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [slpd_pkg::REQ_W-1:0]  req_type,
	input  wire logic [slpd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [slpd_pkg::OFF_W-1:0]  read_offset,
	output slpd_pkg::mem_wr_t                wr,
	output slpd_pkg::mem_rd_t                rd,
	output slpd_pkg::status_t                status
);
	import slpd_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_DATA
	} phase_t;

	localparam logic [LEN_W:0] BUF_N = (LEN_W + 1)'(BUF_BYTES);

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [LEN_W-1:0] len_q [2];
	logic [LEN_W-1:0] len_d [2];
	logic             fill_q, fill_d;
	logic             read_q, read_d;
	logic [LEN_W:0]   n;
	logic             ready_now;
	logic             dropped, ovr, hit;

	assign ready_now = fill_q != read_q;
	assign n = {1'b0, count_q} + (LEN_W + 1)'(1);

	// Next state for one transaction
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		len_d = len_q;
		fill_d = fill_q;
		read_d = read_q;
		dropped = 1'b0;
		ovr = 1'b0;
		hit = 1'b0;
		wr.en = 1'b0;
		wr.addr = fill_q ? ADDR_W'(BUF_BYTES) + ADDR_W'(count_q) : ADDR_W'(count_q);
		wr.data = rx_byte;
		rd.en = 1'b0;
		rd.addr = read_q ? ADDR_W'(BUF_BYTES) + ADDR_W'(read_offset)
		                 : ADDR_W'(read_offset);
		case (req_type)
			REQ_BYTE: begin
				if (rx_byte == START_BYTE) begin
					// Restart the frame
					phase_d = PH_LEN;
					count_d = '0;
					len_d[fill_q] = '0;
				end else begin
					case (phase_q)
						PH_LEN: begin
							if (rx_byte != '0) begin
								len_d[fill_q] = rx_byte;
								count_d = '0;
								phase_d = PH_DATA;
							end
						end
						PH_DATA: begin
							// Store the byte, then publish, drop or abandon
							wr.en = step;
							if (n == {1'b0, len_q[fill_q]}) begin
								if (!ready_now) begin
									fill_d = ~fill_q;
								end else begin
									dropped = 1'b1;
								end
								phase_d = PH_HUNT;
								count_d = '0;
							end else if (n >= BUF_N) begin
								ovr = 1'b1;
								phase_d = PH_HUNT;
								count_d = '0;
							end else begin
								count_d = n[LEN_W-1:0];
							end
						end
						default: begin
						end
					endcase
				end
			end
			REQ_READ: begin
				hit = ready_now
				      && ({1'b0, read_offset} < len_q[read_q])
				      && ((LEN_W + 1)'(read_offset) < BUF_N);
				rd.en = step && hit;
			end
			REQ_RELEASE: begin
				if (ready_now) begin
					read_d = ~read_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Status after the transaction
	always_comb begin
		status.hit = hit;
		status.ready = fill_d != read_d;
		status.length = (fill_d != read_d) ? len_d[read_d] : '0;
		status.dropped = dropped;
		status.overrun = ovr;
	end

	// Hold parse and buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			len_q[0] <= '0;
			len_q[1] <= '0;
			fill_q <= 1'b0;
			read_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q <= len_d;
			fill_q <= fill_d;
			read_q <= read_d;
		end
	end

endmodule

`default_nettype wire

@@ verif/tb_start_length_packet_deframer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_start_length_packet_deframer_unit
// Self-checking bench for the start/length packet deframer.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the parser, the two ping-pong
// buffers and the selects, and derives the status of every accepted
// transaction. The bench first runs a short directed sequence: empty reads
// and releases, the spare request code, a zero length, a restart and a
// dropped frame. It then sends random frames with reads and releases in
// between, plus noise and broken frames. Long frames reach the buffer limit.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the input stalls. Results are checked field by field in
// order.
module tb_start_length_packet_deframer_unit;

	import slpd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 600;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int REPORT_MAX   = 10;

	// Request code with no function in the block
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LENGTH,
		PH_PAYLOAD
	} parse_phase_e;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              ready;
		logic [LEN_W-1:0]  length;
		logic              dropped;
		logic              overrun;
	} deframe_status_t;

	// Tracks deframer state and the status each transaction should return
	class deframe_scoreboard;
		logic [BYTE_W-1:0] store [0:STORE_DEPTH-1];
		logic [LEN_W-1:0]  buf_len [0:1];
		logic              fill_sel;
		logic              read_sel;
		parse_phase_e      phase;
		logic [LEN_W-1:0]  taken;
		deframe_status_t   pending [$];
		int                mismatches;

		function new();
			foreach (store[i])
				store[i] = '0;
			buf_len[0] = '0;
			buf_len[1] = '0;
			fill_sel   = 1'b0;
			read_sel   = 1'b0;
			phase      = PH_HUNT;
			taken      = '0;
			mismatches = 0;
		endfunction

		// Advance the parser and buffers for one accepted transaction
		function void note_request(input logic [REQ_W-1:0] req,
			input logic [BYTE_W-1:0] rx, input logic [OFF_W-1:0] off);
			deframe_status_t exp;
			int unsigned     n;
			exp = '0;
			case (req)
			REQ_BYTE: begin
				if (rx == START_BYTE) begin
					phase            = PH_LENGTH;
					taken            = '0;
					buf_len[fill_sel] = '0;
				end else if (phase == PH_LENGTH) begin
					if (rx != 8'h00) begin
						buf_len[fill_sel] = rx;
						taken            = '0;
						phase            = PH_PAYLOAD;
					end
				end else if (phase == PH_PAYLOAD) begin
					n = 32'(taken);
					if (n < BUF_BYTES)
						store[int'(fill_sel) * BUF_BYTES + n] = rx;
					n++;
					if (n == buf_len[fill_sel]) begin
						// publish if the reader has released the other buffer
						if (fill_sel == read_sel)
							fill_sel = ~fill_sel;
						else
							exp.dropped = 1'b1;
						phase = PH_HUNT;
						taken = '0;
					end else if (n >= BUF_BYTES) begin
						exp.overrun = 1'b1;
						phase       = PH_HUNT;
						taken       = '0;
					end else begin
						taken = n[LEN_W-1:0];
					end
				end
			end
			REQ_READ: begin
				if (fill_sel != read_sel && off < buf_len[read_sel])
					exp.data = store[int'(read_sel) * BUF_BYTES + off];
			end
			REQ_RELEASE: begin
				if (fill_sel != read_sel)
					read_sel = ~read_sel;
			end
			default: ;
			endcase
			exp.ready  = (fill_sel != read_sel);
			exp.length = exp.ready ? buf_len[read_sel] : '0;
			pending.push_back(exp);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(input deframe_status_t got);
			deframe_status_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with nothing expected: %s %h %b %0d %b %b",
						$time, "data/ready/len/drop/ovr", got.data, got.ready,
						got.length, got.dropped, got.overrun);
				return;
			end
			exp = pending.pop_front();
			if (got.data !== exp.data || got.ready !== exp.ready ||
				got.length !== exp.length || got.dropped !== exp.dropped ||
				got.overrun !== exp.overrun) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: mismatch: exp data %h ready %b len %0d drop %b ovr %b",
						$time, exp.data, exp.ready, exp.length, exp.dropped,
						exp.overrun);
					$display("%0t:           got data %h ready %b len %0d drop %b ovr %b",
						$time, got.data, got.ready, got.length, got.dropped,
						got.overrun);
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [REQ_W-1:0]  req_type = '0;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic [OFF_W-1:0]  read_offset = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] read_data;
	logic              packet_ready;
	logic [LEN_W-1:0]  ready_length;
	logic              packet_dropped;
	logic              overrun;

	deframe_scoreboard sb = new();
	int unsigned       cycle_count = 0;
	int                sent_count = 0;
	int                results_seen = 0;

	start_length_packet_deframer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.read_offset    (read_offset),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.packet_ready   (packet_ready),
		.ready_length   (ready_length),
		.packet_dropped (packet_dropped),
		.overrun        (overrun)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_start_length_packet_deframer_unit: done, errors");
			$finish;
		end
	end

	// Idle length: mostly short, a few long, none in quiet windows
	function automatic int pick_gap();
		int r;
		if ((cycle_count / 512) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_request(input logic [REQ_W-1:0] req,
		input logic [BYTE_W-1:0] b, input logic [OFF_W-1:0] off);
		int   gap;
		logic took;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		rx_byte     <= b;
		read_offset <= off;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end
		sb.note_request(req, b, off);
		if (req != REQ_SPARE)
			sent_count++;
	endtask

	// Send one frame; a rare start byte inside the payload breaks it
	task automatic send_frame(input int len);
		int                i;
		logic [BYTE_W-1:0] b;
		logic              restarted;
		restarted = 1'b0;
		send_request(REQ_BYTE, START_BYTE, OFF_W'($urandom));
		if ($urandom_range(0, 7) == 0)
			send_request(REQ_BYTE, 8'h00, OFF_W'($urandom));
		send_request(REQ_BYTE, len[BYTE_W-1:0], OFF_W'($urandom));
		for (i = 0; i < len && !restarted; i++) begin
			b = BYTE_W'($urandom);
			if ($urandom_range(0, 199) == 0)
				b = START_BYTE;
			else if (b == START_BYTE)
				b = ~b;
			restarted = (b == START_BYTE);
			send_request(REQ_BYTE, b, OFF_W'($urandom));
			// interleave reader traffic with the payload now and then
			if ($urandom_range(0, 15) == 0)
				send_request(REQ_READ, BYTE_W'($urandom), OFF_W'($urandom));
		end
	endtask

	// Read some bytes of the published packet, then maybe release it
	task automatic read_packet();
		int               n;
		int               len_now;
		logic [OFF_W-1:0] off;
		n = $urandom_range(0, 4);
		repeat (n) begin
			len_now = int'(sb.buf_len[sb.read_sel]);
			if (len_now == 0 || $urandom_range(0, 3) == 0)
				off = OFF_W'($urandom);
			else
				off = OFF_W'($urandom_range(0, (len_now > 127) ? 127 : len_now));
			send_request(REQ_READ, BYTE_W'($urandom), off);
		end
		if ($urandom_range(0, 2) != 0)
			send_request(REQ_RELEASE, BYTE_W'($urandom), OFF_W'($urandom));
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 31);
		if (r == 0) begin
			case ($urandom_range(0, 4))
			0: return 127;
			1: return 128;
			2: return 129;
			3: return 255;
			default: return $urandom_range(100, 254);
			endcase
		end
		if (r < 4)
			return 1;
		return $urandom_range(3, 24);
	endfunction

	// Result side: random stalls, one long hold-off, check every result
	initial begin : result_side
		deframe_status_t got;
		logic            take;
		int              stall_left;
		bit              hold_done;
		take       = 1'b0;
		stall_left = 0;
		hold_done  = 1'b0;
		got        = '0;
		forever begin
			@(posedge clk);
			if (take) begin
				sb.check_result(got);
				results_seen++;
			end
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			@(negedge clk);
			take = (out_valid === 1'b1) && !out_stall;
			got.data    = read_data;
			got.ready   = packet_ready;
			got.length  = ready_length;
			got.dropped = packet_dropped;
			got.overrun = overrun;
		end
	end

	// Stimulus
	initial begin : request_side
		int                kind;
		bit                paused;
		logic [REQ_W-1:0]  req;
		logic [BYTE_W-1:0] b;
		paused = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty reader requests, spare code, noise while hunting
		send_request(REQ_READ, 8'h00, 7'd0);
		send_request(REQ_RELEASE, 8'hFF, 7'd127);
		send_request(REQ_SPARE, 8'h5A, 7'd42);
		send_request(REQ_BYTE, 8'hFF, 7'd0);
		// one-byte frame behind a skipped zero length
		send_request(REQ_BYTE, START_BYTE, 7'd0);
		send_request(REQ_BYTE, 8'h00, 7'd127);
		send_request(REQ_BYTE, 8'h01, 7'd0);
		send_request(REQ_BYTE, 8'hFF, 7'd0);
		send_request(REQ_READ, 8'h00, 7'd0);
		send_request(REQ_READ, 8'h00, 7'd1);
		send_request(REQ_READ, 8'h00, 7'd127);
		// restart mid payload, then complete while buffer still held: dropped
		send_request(REQ_BYTE, START_BYTE, 7'd0);
		send_request(REQ_BYTE, 8'h03, 7'd0);
		send_request(REQ_BYTE, 8'hAA, 7'd0);
		send_request(REQ_BYTE, START_BYTE, 7'd0);
		send_request(REQ_BYTE, 8'h01, 7'd0);
		send_request(REQ_BYTE, 8'h00, 7'd0);
		send_request(REQ_RELEASE, 8'h00, 7'd0);
		send_request(REQ_READ, 8'h00, 7'd0);
		// publish into the second buffer, read and release
		send_request(REQ_BYTE, START_BYTE, 7'd0);
		send_request(REQ_BYTE, 8'h01, 7'd0);
		send_request(REQ_BYTE, 8'h80, 7'd0);
		send_request(REQ_READ, 8'h00, 7'd0);
		send_request(REQ_RELEASE, 8'h00, 7'd0);

		sent_count = 0;
		while (sent_count < RANDOM_ITEMS) begin
			// pause once until the block has drained
			if (!paused && sent_count >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending.size() != 0)
					@(posedge clk);
			end
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				send_frame(pick_length());
				read_packet();
			end else begin
				// noise: any request code, stray start bytes
				repeat ($urandom_range(1, 6)) begin
					req = REQ_W'($urandom_range(0, 3));
					b = ($urandom_range(0, 4) == 0) ? START_BYTE : BYTE_W'($urandom);
					send_request(req, b, OFF_W'($urandom));
				end
			end
		end
		in_valid <= 1'b0;

		// drain outstanding results
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_start_length_packet_deframer_unit: done, clean");
		else
			$display("tb_start_length_packet_deframer_unit: done, errors");
		$finish;
	end

endmodule
